@@ sv/kinematic_constraint_projection_unit_assert.svh @@
// assertion macros used by the top-level rtl file
`ifndef KINEMATIC_CONSTRAINT_PROJECTION_UNIT_ASSERT_SVH
`define KINEMATIC_CONSTRAINT_PROJECTION_UNIT_ASSERT_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication
`define KCP_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("kcp assertion failed");
// next-cycle implication
`define KCP_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("kcp assertion failed");
`else
`define KCP_ASSERT_IMP(label, clk, rst, ante, cons)
`define KCP_ASSERT_NXT(label, clk, rst, ante, cons)
`endif
`endif

@@ sv/kcp_pkg.sv @@
package kcp_pkg;

   // pipeline depths of the iterative units
   localparam int SQRT_STEPS = 32;
   localparam int DIV_STEPS  = 32;

   // configuration port
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 32;
   localparam int TOL_W      = 31;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_COS_TOL = 2'd0,
      CSR_SIN_TOL = 2'd1
   } csr_idx_type;

   // signed quotient from magnitude, sign and overflow, saturated to 32 bits
   function automatic logic [31:0] sat_div(input logic [31:0] q, input logic ovf,
                                           input logic neg);
      logic [31:0] r;
      if (neg) begin
         r = (ovf || (q > 32'h8000_0000)) ? 32'h8000_0000 : (~q + 32'd1);
      end else begin
         r = (ovf || q[31]) ? 32'h7FFF_FFFF : q;
      end
      return r;
   endfunction

endpackage

@@ sv/kcp_if.sv @@
// input item channel
interface kcp_req_if;
   logic              valid;
   logic              ready;
   logic [1:0]        constraint_count;
   logic signed [31:0] dir_x;
   logic signed [31:0] dir_y;
   logic signed [31:0] dir_z;
   logic signed [31:0] axis_x;
   logic signed [31:0] axis_y;
   logic signed [31:0] axis_z;
   logic signed [31:0] gap_in;
   modport source (output valid, constraint_count, dir_x, dir_y, dir_z,
                   axis_x, axis_y, axis_z, gap_in, input ready);
   modport sink (input valid, constraint_count, dir_x, dir_y, dir_z,
                 axis_x, axis_y, axis_z, gap_in, output ready);
endinterface

// result item channel
interface kcp_rsp_if;
   logic              valid;
   logic              ready;
   logic signed [31:0] new_dir_x;
   logic signed [31:0] new_dir_y;
   logic signed [31:0] new_dir_z;
   logic signed [31:0] gap_out;
   logic              would_violate;
   modport source (output valid, new_dir_x, new_dir_y, new_dir_z, gap_out,
                   would_violate, input ready);
   modport sink (input valid, new_dir_x, new_dir_y, new_dir_z, gap_out,
                 would_violate, output ready);
endinterface

// configuration write channel
interface kcp_csr_if;
   import kcp_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

@@ sv/kinematic_constraint_projection_unit.sv @@
// pipeline: 6 front stages, 32 square-root stages, 1 setup stage, 32 divider
// stages and an output register
// throughput: one item per cycle; the pipeline advances as a whole while the
// output skid register is empty, a result arriving at a stalled output fills
// the skid and the input is held until the output item is taken
// reset: synchronous active high, clears all valid bits and loads the default
// tolerances (cos 0.996, sin 0.087); datapath registers are not reset
module kinematic_constraint_projection_unit #(
   parameter int DIR_FRAC_BITS = 30
) (
   input  logic       clock,
   input  logic       reset,
   kcp_req_if.sink    req_ch,
   kcp_rsp_if.source  rsp_ch,
   kcp_csr_if.sink    csr_ch
);
   import kcp_pkg::*;
`include "kinematic_constraint_projection_unit_assert.svh"

   localparam int F     = DIR_FRAC_BITS;
   localparam int DOT_W = 66 - F;
   localparam int PA_W  = DOT_W + 32;
   localparam int SH_W  = PA_W - F;
   localparam int NW    = 32 + F;
   localparam logic [TOL_W-1:0] COS_RESET =
      TOL_W'(((64'd996 << F) + 64'd500) / 64'd1000);
   localparam logic [TOL_W-1:0] SIN_RESET =
      TOL_W'(((64'd87 << F) + 64'd500) / 64'd1000);

   typedef struct packed {
      logic [1:0]       cnt;
      logic [2:0][31:0] d;
      logic [2:0][31:0] a;
      logic [31:0]      gap;
   } base_type;

   typedef struct packed {
      base_type         b;
      logic [DOT_W-1:0] dot;
      logic [DOT_W-1:0] adot;
      logic             ok1;
      logic             ok2;
      logic [2:0][31:0] p;
   } mid_type;

   typedef struct packed {
      base_type    b;
      logic        viol;
      logic        dneg;
      logic [64:0] gmul;
      logic [2:0]  neg;
   } fin_type;

   typedef struct packed {
      logic [2:0][31:0] dir;
      logic [31:0]      gap;
      logic             viol;
   } out_type;

   // tolerance registers
   logic [TOL_W-1:0] cos_ff;
   logic [TOL_W-1:0] sin_ff;

   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cos_ff <= COS_RESET;
         sin_ff <= SIN_RESET;
      end else if (csr_ch.valid && csr_ch.ready) begin
         case (csr_idx_type'(csr_ch.index))
            CSR_COS_TOL: cos_ff <= csr_ch.data[TOL_W-1:0];
            CSR_SIN_TOL: sin_ff <= csr_ch.data[TOL_W-1:0];
            default: ;
         endcase
      end
   end

   // pipeline enable: everything moves while the skid register is free
   logic en;
   logic sk_v_ff;
   logic out_v_ff;
   assign en = !sk_v_ff;
   assign req_ch.ready = en;

   // stage 1: component products
   base_type         in_b;
   logic             s1_v_ff;
   base_type         s1_b_ff;
   logic [2:0][63:0] s1_prod_ff;
   logic signed [63:0] prod_in [3];

   assign in_b.cnt = req_ch.constraint_count;
   assign in_b.d   = {req_ch.dir_z, req_ch.dir_y, req_ch.dir_x};
   assign in_b.a   = {req_ch.axis_z, req_ch.axis_y, req_ch.axis_x};
   assign in_b.gap = req_ch.gap_in;

   always_comb begin
      for (int i = 0; i < 3; i++) prod_in[i] = $signed(in_b.d[i]) * $signed(in_b.a[i]);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_b_ff <= in_b;
         for (int i = 0; i < 3; i++) s1_prod_ff[i] <= prod_in[i];
      end
   end

   // stage 2: exact dot product, magnitude and tolerance checks
   logic               s2_v_ff;
   mid_type            s2_ff;
   mid_type            s2_in;
   logic signed [65:0] sum;
   logic signed [65:0] sum_sh;

   always_comb begin
      sum = $signed({{2{s1_prod_ff[0][63]}}, s1_prod_ff[0]})
          + $signed({{2{s1_prod_ff[1][63]}}, s1_prod_ff[1]})
          + $signed({{2{s1_prod_ff[2][63]}}, s1_prod_ff[2]});
      sum_sh     = sum >>> F;
      s2_in      = '0;
      s2_in.b    = s1_b_ff;
      s2_in.dot  = sum_sh[DOT_W-1:0];
      s2_in.adot = s2_in.dot[DOT_W-1] ? (~s2_in.dot + DOT_W'(1)) : s2_in.dot;
      s2_in.ok1  = s2_in.adot < DOT_W'(cos_ff);
      s2_in.ok2  = s2_in.adot > DOT_W'(sin_ff);
   end

   always_ff @(posedge clock) begin
      if (en) s2_ff <= s2_in;
   end

   // stage 3: dot times axis
   logic             s3_v_ff;
   mid_type          s3_ff;
   logic [2:0][PA_W-1:0] s3_pa_ff;
   logic signed [PA_W-1:0] pa_in [3];

   always_comb begin
      for (int i = 0; i < 3; i++) pa_in[i] = $signed(s2_ff.dot) * $signed(s2_ff.b.a[i]);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s3_ff <= s2_ff;
         for (int i = 0; i < 3; i++) s3_pa_ff[i] <= pa_in[i];
      end
   end

   // stage 4: remove the constrained component, saturate
   logic               s4_v_ff;
   mid_type            s4_ff;
   mid_type            s4_in;
   logic signed [PA_W-1:0] pa_sh [3];
   logic signed [SH_W:0]   pdiff [3];

   always_comb begin
      s4_in = s3_ff;
      for (int i = 0; i < 3; i++) begin
         pa_sh[i] = $signed(s3_pa_ff[i]) >>> F;
         pdiff[i] = $signed({{(SH_W+1-32){s3_ff.b.d[i][31]}}, s3_ff.b.d[i]})
                  - $signed({pa_sh[i][SH_W-1], pa_sh[i][SH_W-1:0]});
         if (pdiff[i][SH_W:31] == {(SH_W-30){pdiff[i][SH_W]}}) begin
            s4_in.p[i] = pdiff[i][31:0];
         end else begin
            s4_in.p[i] = pdiff[i][SH_W] ? 32'h8000_0000 : 32'h7FFF_FFFF;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) s4_ff <= s4_in;
   end

   // stage 5: squares
   logic             s5_v_ff;
   mid_type          s5_ff;
   logic [2:0][63:0] s5_psq_ff;
   logic signed [63:0] psq_in [3];

   always_comb begin
      for (int i = 0; i < 3; i++) psq_in[i] = $signed(s4_ff.p[i]) * $signed(s4_ff.p[i]);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s5_ff <= s4_ff;
         for (int i = 0; i < 3; i++) s5_psq_ff[i] <= psq_in[i];
      end
   end

   // stage 6: sum of squares
   logic        s6_v_ff;
   mid_type     s6_ff;
   logic [63:0] s6_sq_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         s6_ff    <= s5_ff;
         s6_sq_ff <= s5_psq_ff[0] + s5_psq_ff[1] + s5_psq_ff[2];
      end
   end

   // square root with matching side delay
   logic [31:0]           mag;
   mid_type               sq_side_ff [SQRT_STEPS];
   logic [SQRT_STEPS-1:0] sq_v_ff;

   kcp_isqrt u_isqrt (
      .clock (clock),
      .en    (en),
      .sq    (s6_sq_ff),
      .mag   (mag)
   );

   always_ff @(posedge clock) begin
      if (en) begin
         sq_side_ff[0] <= s6_ff;
         for (int k = 1; k < SQRT_STEPS; k++) sq_side_ff[k] <= sq_side_ff[k-1];
      end
   end

   // stage 7: violation decision, gap scaling product, divider operands
   mid_type                m7;
   fin_type                s7_in;
   fin_type                s7_ff;
   logic                   s7_v_ff;
   logic [2:0][NW-1:0]     num_in;
   logic [2:0][DOT_W-1:0]  den_in;
   logic [2:0][NW-1:0]     s7_num_ff;
   logic [2:0][DOT_W-1:0]  s7_den_ff;
   logic [31:0]            mag_abs [3];
   logic [31:0]            gap_abs;
   logic signed [64:0]     gmul_in;

   assign m7 = sq_side_ff[SQRT_STEPS-1];

   always_comb begin
      s7_in      = '0;
      s7_in.b    = m7.b;
      s7_in.dneg = m7.dot[DOT_W-1];
      case (m7.b.cnt)
         2'd0:    s7_in.viol = 1'b0;
         2'd1:    s7_in.viol = !m7.ok1 || (mag == 32'd0);
         2'd2:    s7_in.viol = !m7.ok2;
         default: s7_in.viol = 1'b1;
      endcase
      gmul_in     = $signed(m7.b.gap) * $signed({1'b0, mag});
      s7_in.gmul  = gmul_in;
      gap_abs     = m7.b.gap[31] ? (~m7.b.gap + 32'd1) : m7.b.gap;
      for (int i = 0; i < 3; i++) begin
         mag_abs[i]   = m7.p[i][31] ? (~m7.p[i] + 32'd1) : m7.p[i];
         num_in[i]    = {mag_abs[i], {F{1'b0}}};
         den_in[i]    = {{(DOT_W-32){1'b0}}, mag};
         s7_in.neg[i] = m7.p[i][31];
      end
      // two constraints: the first divider divides the gap by the dot magnitude instead
      if (m7.b.cnt == 2'd2) begin
         num_in[0]    = {gap_abs, {F{1'b0}}};
         den_in[0]    = m7.adot;
         s7_in.neg[0] = m7.b.gap[31];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s7_ff     <= s7_in;
         s7_num_ff <= num_in;
         s7_den_ff <= den_in;
      end
   end

   // dividers with matching side delay
   logic [2:0][31:0]     dq;
   logic [2:0]           dovf;
   fin_type              dv_side_ff [DIV_STEPS];
   logic [DIV_STEPS-1:0] dv_v_ff;

   for (genvar i = 0; i < 3; i++) begin : g_div
      kcp_div #(.NW(NW), .DW(DOT_W)) u_div (
         .clock (clock),
         .en    (en),
         .num   (s7_num_ff[i]),
         .den   (s7_den_ff[i]),
         .quo   (dq[i]),
         .ovf   (dovf[i])
      );
   end

   always_ff @(posedge clock) begin
      if (en) begin
         dv_side_ff[0] <= s7_ff;
         for (int k = 1; k < DIV_STEPS; k++) dv_side_ff[k] <= dv_side_ff[k-1];
      end
   end

   // valid bits travel with the data
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
         s3_v_ff <= 1'b0;
         s4_v_ff <= 1'b0;
         s5_v_ff <= 1'b0;
         s6_v_ff <= 1'b0;
         sq_v_ff <= '0;
         s7_v_ff <= 1'b0;
         dv_v_ff <= '0;
      end else if (en) begin
         s1_v_ff <= req_ch.valid;
         s2_v_ff <= s1_v_ff;
         s3_v_ff <= s2_v_ff;
         s4_v_ff <= s3_v_ff;
         s5_v_ff <= s4_v_ff;
         s6_v_ff <= s5_v_ff;
         sq_v_ff <= {sq_v_ff[SQRT_STEPS-2:0], s6_v_ff};
         s7_v_ff <= sq_v_ff[SQRT_STEPS-1];
         dv_v_ff <= {dv_v_ff[DIV_STEPS-2:0], s7_v_ff};
      end
   end

   // final selection
   fin_type            fz;
   out_type            res;
   logic signed [64:0] gsh;
   logic [31:0]        gap1;

   assign fz = dv_side_ff[DIV_STEPS-1];

   always_comb begin
      gsh = $signed(fz.gmul) >>> F;
      if (gsh[64:31] == {34{gsh[64]}}) begin
         gap1 = gsh[31:0];
      end else begin
         gap1 = gsh[64] ? 32'h8000_0000 : 32'h7FFF_FFFF;
      end
      res.dir  = fz.b.d;
      res.gap  = fz.b.gap;
      res.viol = fz.viol;
      if (!fz.viol) begin
         case (fz.b.cnt)
            2'd1: begin
               for (int i = 0; i < 3; i++) res.dir[i] = sat_div(dq[i], dovf[i], fz.neg[i]);
               res.gap = gap1;
            end
            2'd2: begin
               for (int i = 0; i < 3; i++) begin
                  if (!fz.dneg) res.dir[i] = fz.b.a[i];
                  else if (fz.b.a[i] == 32'h8000_0000) res.dir[i] = 32'h7FFF_FFFF;
                  else res.dir[i] = ~fz.b.a[i] + 32'd1;
               end
               res.gap = sat_div(dq[0], dovf[0], fz.neg[0]);
            end
            default: ;
         endcase
      end
   end

   // output register with skid
   logic    push;
   logic    take;
   out_type out_ff;
   out_type sk_ff;

   assign push = en && dv_v_ff[DIV_STEPS-1];
   assign take = out_v_ff && rsp_ch.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
         sk_v_ff  <= 1'b0;
      end else if (!out_v_ff || take) begin
         if (sk_v_ff) begin
            out_v_ff <= 1'b1;
            sk_v_ff  <= 1'b0;
         end else begin
            out_v_ff <= push;
         end
      end else if (push) begin
         sk_v_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (!out_v_ff || take) begin
         out_ff <= sk_v_ff ? sk_ff : res;
      end else if (push) begin
         sk_ff <= res;
      end
   end

   assign rsp_ch.valid         = out_v_ff;
   assign rsp_ch.new_dir_x     = out_ff.dir[0];
   assign rsp_ch.new_dir_y     = out_ff.dir[1];
   assign rsp_ch.new_dir_z     = out_ff.dir[2];
   assign rsp_ch.gap_out       = out_ff.gap;
   assign rsp_ch.would_violate = out_ff.viol;

   // skid holds an item only behind a held output item
   `KCP_ASSERT_IMP(a_skid_behind_out, clock, reset, sk_v_ff, out_v_ff)
   // a result arriving at a stalled output lands in the skid
   `KCP_ASSERT_NXT(a_stall_to_skid, clock, reset, out_v_ff && !rsp_ch.ready && push,
                   sk_v_ff)
   // a taken output with a full skid refills from the skid
   `KCP_ASSERT_NXT(a_skid_drain, clock, reset, sk_v_ff && rsp_ch.ready,
                   out_v_ff && !sk_v_ff)

endmodule

@@ sv/kcp_isqrt.sv @@
module kcp_isqrt (
   input  logic        clock,
   input  logic        en,
   input  logic [63:0] sq,
   output logic [31:0] mag
);
   import kcp_pkg::*;

   typedef struct packed {
      logic [63:0] n;
      logic [63:0] res;
   } sq_stage_type;

   sq_stage_type st_ff [SQRT_STEPS];
   sq_stage_type st_in [SQRT_STEPS];

   // one result bit per stage, bit walks down two places each step
   for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_step
      localparam logic [63:0] BIT = 64'd1 << (62 - 2 * k);
      sq_stage_type prev;
      always_comb begin
         if (k == 0) begin
            prev.n   = sq;
            prev.res = 64'd0;
         end else begin
            prev = st_ff[(k == 0) ? 0 : k - 1];
         end
         if (prev.n >= prev.res + BIT) begin
            st_in[k].n   = prev.n - (prev.res + BIT);
            st_in[k].res = (prev.res >> 1) + BIT;
         end else begin
            st_in[k].n   = prev.n;
            st_in[k].res = prev.res >> 1;
         end
      end
      always_ff @(posedge clock) begin
         if (en) st_ff[k] <= st_in[k];
      end
   end

   assign mag = st_ff[SQRT_STEPS-1].res[31:0];

endmodule

@@ sv/kcp_div.sv @@
module kcp_div #(
   parameter int NW = 62,
   parameter int DW = 36
) (
   input  logic          clock,
   input  logic          en,
   input  logic [NW-1:0] num,
   input  logic [DW-1:0] den,
   output logic [31:0]   quo,
   output logic          ovf
);
   import kcp_pkg::*;

   typedef struct packed {
      logic [DW-1:0] rem;
      logic [31:0]   lo;
      logic [31:0]   q;
      logic          ovf;
      logic [DW-1:0] den;
   } div_stage_type;

   div_stage_type st_ff [DIV_STEPS];
   div_stage_type st_in [DIV_STEPS];
   logic [DW-1:0] rem_init;

   // upper numerator bits seed the remainder; at or above the divisor the quotient overflows
   assign rem_init = {{(DW-(NW-32)){1'b0}}, num[NW-1:32]};

   // restoring division, one quotient bit per stage
   for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
      div_stage_type prev;
      logic [DW:0]   trial;
      logic [DW:0]   diff;
      always_comb begin
         if (k == 0) begin
            prev.rem = rem_init;
            prev.lo  = num[31:0];
            prev.q   = 32'd0;
            prev.ovf = (rem_init >= den);
            prev.den = den;
         end else begin
            prev = st_ff[(k == 0) ? 0 : k - 1];
         end
         trial = {prev.rem, prev.lo[31]};
         diff  = trial - {1'b0, prev.den};
         st_in[k].lo  = {prev.lo[30:0], 1'b0};
         st_in[k].ovf = prev.ovf;
         st_in[k].den = prev.den;
         if (trial >= {1'b0, prev.den}) begin
            st_in[k].rem = diff[DW-1:0];
            st_in[k].q   = {prev.q[30:0], 1'b1};
         end else begin
            st_in[k].rem = trial[DW-1:0];
            st_in[k].q   = {prev.q[30:0], 1'b0};
         end
      end
      always_ff @(posedge clock) begin
         if (en) st_ff[k] <= st_in[k];
      end
   end

   assign quo = st_ff[DIV_STEPS-1].q;
   assign ovf = st_ff[DIV_STEPS-1].ovf;

endmodule
